>>> rtl/core/nhe_pkg.sv
// Shared types and constants for the NAND Hamming ECC block.
package nhe_pkg;

    localparam int NHE_OFFSET_BITS = 9;
    localparam int NHE_CHUNKS      = 4;
    localparam int NHE_WORD_W      = 16;
    localparam int NHE_IDX_W       = 2;

    localparam logic [7:0] MASK_C0_EVEN = 8'h55;
    localparam logic [7:0] MASK_C0_ODD  = 8'haa;
    localparam logic [7:0] MASK_C1_EVEN = 8'h33;
    localparam logic [7:0] MASK_C1_ODD  = 8'hcc;
    localparam logic [7:0] MASK_C2_EVEN = 8'h0f;
    localparam logic [7:0] MASK_C2_ODD  = 8'hf0;

    typedef enum logic [1:0] {
        SEL_EVEN_LO = 2'd0,
        SEL_EVEN_HI = 2'd1,
        SEL_ODD_LO  = 2'd2,
        SEL_ODD_HI  = 2'd3
    } t_ecc_sel;

    typedef struct packed {
        logic [NHE_WORD_W-1:0] even;
        logic [NHE_WORD_W-1:0] odd;
        logic [NHE_IDX_W-1:0]  idx;
    } t_ecc_word;

endpackage

>>> rtl/core/nand_hamming_ecc_512.sv
// Top level of the NAND Hamming ECC generator over 512-byte chunks.
//
//   Channel  Direction  Handshake           Per beat
//   input    in         i_valid / o_stall   i_data_byte
//   output   out        o_valid / i_stall   o_ecc_byte, o_chunk_index, o_last
//
// One data byte is taken every cycle while o_stall is low; it is folded into the
// parity registers in the cycle it is accepted. The last byte of a chunk loads the
// result register, which then sends four ECC beats starting in the next cycle. Only a
// chunk's last byte can stall, and only while the result register still holds beats of
// the previous chunk, unless its final beat leaves in that same cycle.
// Synchronous reset clears the offset, chunk counter, accumulators and pending beats.
module nand_hamming_ecc_512
    #(
    parameter int OFFSET_BITS     = nhe_pkg::NHE_OFFSET_BITS,
    parameter int CHUNKS_PER_PAGE = nhe_pkg::NHE_CHUNKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_ecc_byte,
    output logic [nhe_pkg::NHE_IDX_W-1:0] o_chunk_index,
    output logic                          o_last
);
    import nhe_pkg::*;

    logic      chunk_end;
    logic      load;
    logic      free;
    logic      fire;
    t_ecc_word word;

    assign o_stall = chunk_end && !free;
    assign fire    = i_valid && !o_stall;

    nhe_accum #(
        .OFFSET_BITS     (OFFSET_BITS),
        .CHUNKS_PER_PAGE (CHUNKS_PER_PAGE)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_data_byte),
        .o_chunk_end (chunk_end),
        .o_load      (load),
        .o_word      (word)
    );

    nhe_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_word        (word),
        .o_free        (free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ecc_byte    (o_ecc_byte),
        .o_chunk_index (o_chunk_index),
        .o_last        (o_last)
    );

endmodule

>>> rtl/core/nhe_accum.sv
// Line and column parity accumulation over one chunk and packing of the ECC words.
module nhe_accum #(
    parameter int OFFSET_BITS     = nhe_pkg::NHE_OFFSET_BITS,
    parameter int CHUNKS_PER_PAGE = nhe_pkg::NHE_CHUNKS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_data_byte,
    output logic                o_chunk_end,
    output logic                o_load,
    output nhe_pkg::t_ecc_word  o_word
);
    import nhe_pkg::*;

    localparam logic [NHE_IDX_W-1:0] CHUNK_LAST = NHE_IDX_W'(CHUNKS_PER_PAGE - 1);

    logic [7:0]             r_acc [OFFSET_BITS][2];
    logic [7:0]             n_acc [OFFSET_BITS][2];
    logic [OFFSET_BITS-1:0] r_offset;
    logic [NHE_IDX_W-1:0]   r_chunk;
    logic [7:0]             col;
    logic [NHE_WORD_W-1:0]  even;
    logic [NHE_WORD_W-1:0]  odd;

    assign o_chunk_end = &r_offset;

    always_comb begin
        for (int j = 0; j < OFFSET_BITS; j++) begin
            n_acc[j][0] = r_acc[j][0] ^ (r_offset[j] ? 8'h00 : i_data_byte);
            n_acc[j][1] = r_acc[j][1] ^ (r_offset[j] ? i_data_byte : 8'h00);
        end
        col  = n_acc[0][0] ^ n_acc[0][1];
        even = '0;
        odd  = '0;
        even[0] = ^(col & MASK_C0_EVEN);
        even[1] = ^(col & MASK_C1_EVEN);
        even[2] = ^(col & MASK_C2_EVEN);
        odd[0]  = ^(col & MASK_C0_ODD);
        odd[1]  = ^(col & MASK_C1_ODD);
        odd[2]  = ^(col & MASK_C2_ODD);
        for (int j = 0; j < OFFSET_BITS; j++) begin
            even[3+j] = ^n_acc[j][0];
            odd[3+j]  = ^n_acc[j][1];
        end
    end

    assign o_load      = i_fire && o_chunk_end;
    assign o_word.even = even;
    assign o_word.odd  = odd;
    assign o_word.idx  = r_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_chunk  <= '0;
            for (int j = 0; j < OFFSET_BITS; j++) begin
                r_acc[j][0] <= 8'h00;
                r_acc[j][1] <= 8'h00;
            end
        end else if (i_fire) begin
            r_offset <= r_offset + 1'b1;
            if (o_chunk_end) begin
                r_chunk <= (r_chunk == CHUNK_LAST) ? '0 : r_chunk + 1'b1;
                for (int j = 0; j < OFFSET_BITS; j++) begin
                    r_acc[j][0] <= 8'h00;
                    r_acc[j][1] <= 8'h00;
                end
            end else begin
                r_acc <= n_acc;
            end
        end
    end

endmodule

>>> rtl/core/nhe_out.sv
// Result register that holds one chunk's ECC words and sends them as four byte beats.
module nhe_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  nhe_pkg::t_ecc_word            i_word,
    output logic                          o_free,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_ecc_byte,
    output logic [nhe_pkg::NHE_IDX_W-1:0] o_chunk_index,
    output logic                          o_last
);
    import nhe_pkg::*;

    t_ecc_word  r_word;
    t_ecc_sel   r_sel;
    logic [2:0] r_left;
    logic       out_fire;

    assign o_valid  = (r_left != 3'd0);
    assign out_fire = o_valid && !i_stall;
    assign o_free   = !o_valid || ((r_left == 3'd1) && out_fire);

    always_comb begin
        unique case (r_sel)
            SEL_EVEN_LO: o_ecc_byte = r_word.even[7:0];
            SEL_EVEN_HI: o_ecc_byte = r_word.even[15:8];
            SEL_ODD_LO:  o_ecc_byte = r_word.odd[7:0];
            SEL_ODD_HI:  o_ecc_byte = r_word.odd[15:8];
            default:     o_ecc_byte = 8'h00;
        endcase
    end

    assign o_chunk_index = r_word.idx;
    assign o_last        = (r_sel == SEL_ODD_HI);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_sel  <= SEL_EVEN_LO;
        end else if (i_load) begin
            r_left <= 3'd4;
            r_sel  <= SEL_EVEN_LO;
        end else if (out_fire) begin
            r_left <= r_left - 3'd1;
            r_sel  <= t_ecc_sel'(r_sel + 2'd1);
        end
    end

endmodule

>>> test/tb_nand_hamming_ecc_512.sv
// Self-checking testbench for the NAND Hamming ECC generator over 512-byte chunks.
module tb_nand_hamming_ecc_512;
    timeunit 1ns;
    timeprecision 1ps;

    import nhe_pkg::*;

    localparam int NB          = NHE_OFFSET_BITS;
    localparam int CHUNK_LEN   = 1 << NB;
    localparam int HOLD_CYCLES = 2500;
    localparam int IDLE_LIMIT  = 8000;
    localparam int RAND_CHUNKS = 12;

    typedef enum logic [1:0] {
        CH_FILL,
        CH_SINGLE,
        CH_RANDOM,
        CH_SPARSE
    } t_chunk_kind;

    typedef struct packed {
        t_chunk_kind     kind;
        logic [7:0]      fill;
        logic [NB-1:0]   pos;
        logic [7:0]      val;
        logic            typed;
        logic [31:0]     ecc_words;
    } t_chunk_row;

    typedef struct {
        logic [7:0]           ecc;
        logic [NHE_IDX_W-1:0] idx;
        logic                 last;
    } t_ecc_beat;

    localparam t_chunk_row DIRECTED_ROWS [6] = '{
        '{CH_FILL,   8'h00, 9'd0,   8'h00, 1'b1, 32'h0000_0000},
        '{CH_FILL,   8'hff, 9'd0,   8'h00, 1'b1, 32'h0000_0000},
        '{CH_SINGLE, 8'h00, 9'd0,   8'h01, 1'b1, 32'h0000_0fff},
        '{CH_SINGLE, 8'h00, 9'd511, 8'h80, 1'b1, 32'h0fff_0000},
        '{CH_SINGLE, 8'h3c, 9'h155, 8'ha5, 1'b0, 32'h0000_0000},
        '{CH_RANDOM, 8'h00, 9'd0,   8'h00, 1'b0, 32'h0000_0000}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [7:0]           i_data_byte;
    logic                 o_valid;
    logic                 i_stall;
    logic [7:0]           o_ecc_byte;
    logic [NHE_IDX_W-1:0] o_chunk_index;
    logic                 o_last;

    logic [7:0]           line_even [NB];
    logic [7:0]           line_odd [NB];
    logic [NB-1:0]        page_offset;
    logic [NHE_IDX_W-1:0] chunk_no;
    t_ecc_beat            ecc_beats_due[$];
    logic [7:0]           chunk_buf [CHUNK_LEN];
    logic                 typed_valid;
    logic [31:0]          typed_ecc;
    int                   beats_seen;
    int                   idle_cycles;
    int                   burst_left;
    bit                   failed;

    nand_hamming_ecc_512 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ecc_byte    (o_ecc_byte),
        .o_chunk_index (o_chunk_index),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic clear_lines();
        for (int j = 0; j < NB; j++) begin
            line_even[j] = '0;
            line_odd[j]  = '0;
        end
    endtask

    task automatic fold_page_byte(input logic [7:0] b);
        logic [7:0] col;
        t_ecc_word  w;
        t_ecc_beat  beat;
        t_ecc_sel   sel;
        for (int j = 0; j < NB; j++) begin
            if (page_offset[j]) begin
                line_odd[j] ^= b;
            end else begin
                line_even[j] ^= b;
            end
        end
        if (page_offset != NB'(CHUNK_LEN - 1)) begin
            page_offset++;
        end else begin
            col = line_even[0] ^ line_odd[0];
            w.even = '0;
            w.odd  = '0;
            w.idx  = chunk_no;
            w.even[0] = ^(col & MASK_C0_EVEN);
            w.even[1] = ^(col & MASK_C1_EVEN);
            w.even[2] = ^(col & MASK_C2_EVEN);
            w.odd[0]  = ^(col & MASK_C0_ODD);
            w.odd[1]  = ^(col & MASK_C1_ODD);
            w.odd[2]  = ^(col & MASK_C2_ODD);
            for (int j = 0; j < NB; j++) begin
                w.even[3 + j] = ^line_even[j];
                w.odd[3 + j]  = ^line_odd[j];
            end
            if (typed_valid) begin
                w.even = typed_ecc[15:0];
                w.odd  = typed_ecc[31:16];
            end
            for (int k = 0; k < 4; k++) begin
                sel = t_ecc_sel'(k);
                case (sel)
                    SEL_EVEN_LO: beat.ecc = w.even[7:0];
                    SEL_EVEN_HI: beat.ecc = w.even[15:8];
                    SEL_ODD_LO:  beat.ecc = w.odd[7:0];
                    default:     beat.ecc = w.odd[15:8];
                endcase
                beat.idx  = w.idx;
                beat.last = (sel == SEL_ODD_HI);
                ecc_beats_due.push_back(beat);
            end
            clear_lines();
            page_offset = '0;
            chunk_no = (int'(chunk_no) >= NHE_CHUNKS - 1) ? '0 : chunk_no + 1'b1;
        end
    endtask

    task automatic check_ecc_beat();
        t_ecc_beat due;
        if (ecc_beats_due.size() == 0) begin
            $error("ECC beat with nothing expected: ecc_byte %h", o_ecc_byte);
            failed = 1'b1;
        end else begin
            due = ecc_beats_due.pop_front();
            if (o_ecc_byte !== due.ecc) begin
                $error("ecc_byte: expected %h, actual %h", due.ecc, o_ecc_byte);
                failed = 1'b1;
            end
            if (o_chunk_index !== due.idx) begin
                $error("chunk_index: expected %0d, actual %0d", due.idx, o_chunk_index);
                failed = 1'b1;
            end
            if (o_last !== due.last) begin
                $error("last: expected %b, actual %b", due.last, o_last);
                failed = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                fold_page_byte(i_data_byte);
            end
            if (o_valid && !i_stall) begin
                beats_seen++;
                check_ecc_beat();
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int mode;
        int left;
        bit held;
        i_stall = 1'b0;
        held = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (!held && beats_seen >= 12) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(16, 128);
            end
            left--;
            case (mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 64);
            r = $urandom_range(0, 15);
            gap = (r < 6) ? 0 : (r < 14) ? $urandom_range(1, 6) : $urandom_range(20, 60);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic make_chunk(input t_chunk_kind kind, input logic [7:0] fill,
                              input logic [NB-1:0] pos, input logic [7:0] val);
        for (int i = 0; i < CHUNK_LEN; i++) begin
            case (kind)
                CH_RANDOM: chunk_buf[i] = 8'($urandom);
                CH_SPARSE: chunk_buf[i] = 8'h00;
                default:   chunk_buf[i] = fill;
            endcase
        end
        if (kind == CH_SINGLE) begin
            chunk_buf[pos] = val;
        end else if (kind == CH_SPARSE) begin
            repeat ($urandom_range(1, 8)) chunk_buf[$urandom_range(0, CHUNK_LEN - 1)] = 8'($urandom);
        end
    endtask

    task automatic send_chunk();
        for (int i = 0; i < CHUNK_LEN; i++) begin
            send_byte(chunk_buf[i]);
        end
    endtask

    initial begin
        t_chunk_kind kind;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        typed_valid = 1'b0;
        typed_ecc   = '0;
        beats_seen  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        failed      = 1'b0;
        page_offset = '0;
        chunk_no    = '0;
        clear_lines();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            typed_valid = DIRECTED_ROWS[r].typed;
            typed_ecc   = DIRECTED_ROWS[r].ecc_words;
            make_chunk(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].fill,
                       DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].val);
            send_chunk();
        end

        i_valid <= 1'b0;
        while (ecc_beats_due.size() != 0) @(negedge i_clk);

        typed_valid = 1'b0;
        for (int c = 0; c < RAND_CHUNKS; c++) begin
            kind = t_chunk_kind'($urandom_range(0, 3));
            make_chunk(kind, 8'($urandom), NB'($urandom), 8'($urandom));
            send_chunk();
        end
        repeat ($urandom_range(1, 300)) send_byte(8'($urandom));

        i_valid <= 1'b0;
        while (ecc_beats_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed && ecc_beats_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> nand_hamming_ecc_512.f
rtl/core/nhe_pkg.sv
rtl/core/nhe_accum.sv
rtl/core/nhe_out.sv
rtl/core/nand_hamming_ecc_512.sv
test/tb_nand_hamming_ecc_512.sv
